@@ rtl/core/mfrb_pkg.sv @@
// Shared constants, command codes and beat types of the frame ring buffer.
`default_nettype none
package mfrb_pkg;

  localparam int DEPTH_FRAMES = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_BURST    = 64;

  localparam int SAMPLE_W   = 32;
  localparam int LANES      = 8;
  localparam int CMD_W      = 3;
  localparam int CNT_W      = 11;
  localparam int GEN_W      = 16;
  localparam int CH_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IDX_W      = $clog2(DEPTH_FRAMES);
  localparam int BURST_W    = $clog2(MAX_BURST + 1);
  localparam int WIDE_W     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int FRAME_W    = MAX_CHANNELS * SAMPLE_W;

  localparam int CAP_LIMIT  = (1 << CNT_W) - 1;
  localparam int CAP_MAX    = (DEPTH_FRAMES < CAP_LIMIT) ? DEPTH_FRAMES : CAP_LIMIT;
  localparam int CAP_RESET  = (DEPTH_FRAMES < 1024) ? DEPTH_FRAMES : 1024;
  localparam int CH_RESET   = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_START = 3'd0,
    CMD_PUSH_FRAME = 3'd1,
    CMD_POP        = 3'd2,
    CMD_PEEK       = 3'd3,
    CMD_DISCARD    = 3'd4,
    CMD_RESET      = 3'd5
  } mfrb_cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]                command;
    logic [CNT_W-1:0]                frame_count;
    logic [GEN_W-1:0]                generation_tag;
    logic [LANES-1:0][SAMPLE_W-1:0]  samples;
  } mfrb_in_beat_t;

  typedef struct packed {
    logic                            accepted;
    logic [CNT_W-1:0]                count_done;
    logic [LANES-1:0][SAMPLE_W-1:0]  samples;
    logic                            last_of_run;
  } mfrb_out_beat_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic frame_load;
  } mfrb_ctl_t;

  typedef struct packed {
    logic burst_start;
    logic burst_last;
    logic out_free;
  } mfrb_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/mfrb_if.sv @@
// Handshake channel interfaces: input beats, result beats and register writes.
`default_nettype none
interface mfrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [mfrb_pkg::CMD_W-1:0]     command;
  logic [mfrb_pkg::CNT_W-1:0]     frame_count;
  logic [mfrb_pkg::GEN_W-1:0]     generation_tag;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch0;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch1;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch2;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch3;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch4;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch5;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch6;
  logic [mfrb_pkg::SAMPLE_W-1:0]  sample_ch7;

  modport source (output valid, command, frame_count, generation_tag, sample_ch0, sample_ch1,
                  sample_ch2, sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                  input ready);
  modport sink (input valid, command, frame_count, generation_tag, sample_ch0, sample_ch1,
                sample_ch2, sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                output ready);
endinterface

interface mfrb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [mfrb_pkg::CNT_W-1:0]     count_done;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch0;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch1;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch2;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch3;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch4;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch5;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch6;
  logic [mfrb_pkg::SAMPLE_W-1:0]  out_ch7;
  logic                           last_of_run;

  modport source (output valid, accepted, count_done, out_ch0, out_ch1, out_ch2, out_ch3,
                  out_ch4, out_ch5, out_ch6, out_ch7, last_of_run, input ready);
  modport sink (input valid, accepted, count_done, out_ch0, out_ch1, out_ch2, out_ch3,
                out_ch4, out_ch5, out_ch6, out_ch7, last_of_run, output ready);
endinterface

interface mfrb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mfrb_pkg::CFG_IDX_W-1:0]    index;
  logic [mfrb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mfrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/mfrb_ctrl.sv @@
// Command sequencer: takes input beats and steps pop/peek bursts frame by frame.
`default_nettype none
module mfrb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mfrb_pkg::mfrb_sts_t  sts,
  output mfrb_pkg::mfrb_ctl_t       ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } mfrb_state_t;

  mfrb_state_t state_r;
  mfrb_state_t state_nxt;
  logic        take;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    take      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        take     = in_valid && sts.out_free;
        ctl.take = take;
        if (take && sts.burst_start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          ctl.frame_load = 1'b1;
          state_nxt      = sts.burst_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_issue |=> (state_r == ST_LOAD))
    else $error("read issue not followed by load");
  a_take_only_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> sts.out_free)
    else $error("input taken while result register busy");
  a_last_frame_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.frame_load && sts.burst_last) |=> (state_r == ST_IDLE))
    else $error("burst did not end after last frame");
`endif

endmodule
`default_nettype wire

@@ rtl/core/mfrb_dp.sv @@
// Ring datapath: config, pointers, push run tracking, sample RAM and result register.
`default_nettype none
module mfrb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  input  wire logic [mfrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mfrb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire mfrb_pkg::mfrb_in_beat_t             in_beat,
  input  wire mfrb_pkg::mfrb_ctl_t                 ctl,
  output mfrb_pkg::mfrb_sts_t                      sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output mfrb_pkg::mfrb_out_beat_t                 out_beat
);

  logic [mfrb_pkg::CH_W-1:0]     ch_cnt_r;
  logic [mfrb_pkg::CNT_W-1:0]    cap_r;
  logic [mfrb_pkg::IDX_W-1:0]    rd_idx_r;
  logic [mfrb_pkg::IDX_W-1:0]    wr_idx_r;
  logic [mfrb_pkg::CNT_W-1:0]    fill_r;
  logic [mfrb_pkg::GEN_W-1:0]    gen_r;
  logic [mfrb_pkg::CNT_W-1:0]    push_rem_r;
  logic [mfrb_pkg::CNT_W-1:0]    push_res_r;
  logic [mfrb_pkg::IDX_W-1:0]    push_slot_r;
  logic [mfrb_pkg::BURST_W-1:0]  burst_n_r;
  logic [mfrb_pkg::BURST_W-1:0]  burst_k_r;
  logic [mfrb_pkg::IDX_W-1:0]    burst_slot_r;
  logic                          burst_pop_r;
  logic                          out_valid_r;
  mfrb_pkg::mfrb_out_beat_t      out_beat_r;

  mfrb_pkg::mfrb_cmd_t           cmd;
  logic [mfrb_pkg::CNT_W-1:0]    req;
  logic [mfrb_pkg::CNT_W-1:0]    avail;
  logic [mfrb_pkg::BURST_W-1:0]  burst_n;
  logic [mfrb_pkg::CNT_W-1:0]    free_frames;
  logic                          push_ok;
  logic                          is_read_cmd;
  logic                          burst_last;
  logic                          out_free;
  logic                          push_wr;
  logic [mfrb_pkg::WIDE_W-1:0]   disc_sum;
  logic [mfrb_pkg::IDX_W-1:0]    disc_idx;
  logic [mfrb_pkg::CNT_W:0]      fill_sum;
  logic [mfrb_pkg::CNT_W-1:0]    fill_pub;
  logic [mfrb_pkg::CH_W-1:0]     cfg_ch;
  logic [mfrb_pkg::CNT_W-1:0]    cfg_cap;
  logic [mfrb_pkg::FRAME_W-1:0]  ram_wr_data;
  logic [mfrb_pkg::FRAME_W-1:0]  ram_rd_data;
  logic [mfrb_pkg::MAX_CHANNELS-1:0][mfrb_pkg::SAMPLE_W-1:0] rd_lanes;
  mfrb_pkg::mfrb_out_beat_t      single_beat;
  mfrb_pkg::mfrb_out_beat_t      frame_beat;

  function automatic logic [mfrb_pkg::IDX_W-1:0] slot_inc(
    input logic [mfrb_pkg::IDX_W-1:0] s,
    input logic [mfrb_pkg::CNT_W-1:0] cap
  );
    logic [mfrb_pkg::WIDE_W-1:0] t;
    t = mfrb_pkg::WIDE_W'(s) + mfrb_pkg::WIDE_W'(1);
    return (t >= mfrb_pkg::WIDE_W'(cap)) ? '0 : t[mfrb_pkg::IDX_W-1:0];
  endfunction

  assign cmd         = mfrb_pkg::mfrb_cmd_t'(in_beat.command);
  assign req         = in_beat.frame_count;
  assign avail       = (req > fill_r) ? fill_r : req;
  assign burst_n     = (avail > mfrb_pkg::CNT_W'(mfrb_pkg::MAX_BURST)) ?
                       mfrb_pkg::BURST_W'(mfrb_pkg::MAX_BURST) : avail[mfrb_pkg::BURST_W-1:0];
  assign free_frames = cap_r - fill_r;
  assign push_ok     = (in_beat.generation_tag == gen_r) && (req <= free_frames);
  assign is_read_cmd = (cmd == mfrb_pkg::CMD_POP) || (cmd == mfrb_pkg::CMD_PEEK);
  assign burst_last  = ((burst_k_r + mfrb_pkg::BURST_W'(1)) == burst_n_r);
  assign out_free    = !out_valid_r || out_ready;
  assign push_wr     = ctl.take && (cmd == mfrb_pkg::CMD_PUSH_FRAME) && (push_rem_r != '0);

  assign disc_sum = mfrb_pkg::WIDE_W'(rd_idx_r) + mfrb_pkg::WIDE_W'(avail);
  assign disc_idx = (disc_sum >= mfrb_pkg::WIDE_W'(cap_r)) ?
                    mfrb_pkg::IDX_W'(disc_sum - mfrb_pkg::WIDE_W'(cap_r)) :
                    disc_sum[mfrb_pkg::IDX_W-1:0];

  assign fill_sum = {1'b0, fill_r} + {1'b0, push_res_r};
  assign fill_pub = (fill_sum > {1'b0, cap_r}) ? cap_r : fill_sum[mfrb_pkg::CNT_W-1:0];

  always_comb begin
    cfg_ch = cfg_data[mfrb_pkg::CH_W-1:0];
    if (cfg_ch == '0) begin
      cfg_ch = mfrb_pkg::CH_W'(1);
    end else if (cfg_ch > mfrb_pkg::CH_W'(mfrb_pkg::MAX_CHANNELS)) begin
      cfg_ch = mfrb_pkg::CH_W'(mfrb_pkg::MAX_CHANNELS);
    end
    cfg_cap = cfg_data[mfrb_pkg::CNT_W-1:0];
    if (cfg_cap == '0) begin
      cfg_cap = mfrb_pkg::CNT_W'(1);
    end else if (mfrb_pkg::WIDE_W'(cfg_cap) > mfrb_pkg::WIDE_W'(mfrb_pkg::CAP_MAX)) begin
      cfg_cap = mfrb_pkg::CNT_W'(mfrb_pkg::CAP_MAX);
    end
  end

  assign ram_wr_data = in_beat.samples[mfrb_pkg::MAX_CHANNELS-1:0];
  assign rd_lanes    = ram_rd_data;

  mfrb_ram #(
    .WIDTH (mfrb_pkg::FRAME_W),
    .DEPTH (mfrb_pkg::DEPTH_FRAMES)
  ) u_store (
    .clk     (clk),
    .wr_en   (push_wr),
    .wr_addr (push_slot_r),
    .wr_data (ram_wr_data),
    .rd_en   (ctl.rd_issue),
    .rd_addr (burst_slot_r),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    single_beat             = '0;
    single_beat.accepted    = (cmd == mfrb_pkg::CMD_PUSH_START) ? push_ok : 1'b1;
    single_beat.count_done  = (cmd == mfrb_pkg::CMD_DISCARD) ? avail : '0;
    single_beat.last_of_run = 1'b1;

    frame_beat             = '0;
    frame_beat.accepted    = 1'b1;
    frame_beat.count_done  = mfrb_pkg::CNT_W'(burst_n_r);
    frame_beat.last_of_run = burst_last;
    for (int j = 0; j < mfrb_pkg::MAX_CHANNELS; j++) begin
      if (mfrb_pkg::CH_W'(j) < ch_cnt_r) begin
        frame_beat.samples[j] = rd_lanes[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.frame_load) begin
      out_beat_r <= frame_beat;
    end else if (ctl.take && !(is_read_cmd && (avail != '0))) begin
      out_beat_r <= single_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r     <= mfrb_pkg::CH_W'(mfrb_pkg::CH_RESET);
      cap_r        <= mfrb_pkg::CNT_W'(mfrb_pkg::CAP_RESET);
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      fill_r       <= '0;
      gen_r        <= '0;
      push_rem_r   <= '0;
      push_res_r   <= '0;
      push_slot_r  <= '0;
      burst_n_r    <= '0;
      burst_k_r    <= '0;
      burst_slot_r <= '0;
      burst_pop_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.frame_load || (ctl.take && !(is_read_cmd && (avail != '0)))) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (ctl.take) begin
        case (cmd)
          mfrb_pkg::CMD_PUSH_START: begin
            push_rem_r <= push_ok ? req : '0;
            push_res_r <= push_ok ? req : '0;
            if (push_ok) begin
              push_slot_r <= wr_idx_r;
            end
          end
          mfrb_pkg::CMD_PUSH_FRAME: begin
            if (push_rem_r != '0) begin
              push_slot_r <= slot_inc(push_slot_r, cap_r);
              push_rem_r  <= push_rem_r - mfrb_pkg::CNT_W'(1);
              if (push_rem_r == mfrb_pkg::CNT_W'(1)) begin
                wr_idx_r   <= slot_inc(push_slot_r, cap_r);
                fill_r     <= fill_pub;
                push_res_r <= '0;
              end
            end
          end
          mfrb_pkg::CMD_POP, mfrb_pkg::CMD_PEEK: begin
            burst_n_r    <= burst_n;
            burst_k_r    <= '0;
            burst_slot_r <= rd_idx_r;
            burst_pop_r  <= (cmd == mfrb_pkg::CMD_POP);
          end
          mfrb_pkg::CMD_DISCARD: begin
            rd_idx_r <= disc_idx;
            fill_r   <= fill_r - avail;
          end
          mfrb_pkg::CMD_RESET: begin
            gen_r       <= in_beat.generation_tag;
            rd_idx_r    <= wr_idx_r;
            fill_r      <= '0;
            push_rem_r  <= '0;
            push_res_r  <= '0;
            push_slot_r <= wr_idx_r;
          end
          default: begin
          end
        endcase
      end

      if (ctl.frame_load) begin
        burst_slot_r <= slot_inc(burst_slot_r, cap_r);
        burst_k_r    <= burst_k_r + mfrb_pkg::BURST_W'(1);
        if (burst_last && burst_pop_r) begin
          rd_idx_r <= slot_inc(burst_slot_r, cap_r);
          fill_r   <= fill_r - mfrb_pkg::CNT_W'(burst_n_r);
        end
      end

      if (cfg_valid && ((cfg_index == mfrb_pkg::CFG_CHANNEL_COUNT) ||
                        (cfg_index == mfrb_pkg::CFG_CAPACITY))) begin
        if (cfg_index == mfrb_pkg::CFG_CHANNEL_COUNT) begin
          ch_cnt_r <= cfg_ch;
        end else begin
          cap_r <= cfg_cap;
        end
        rd_idx_r    <= '0;
        wr_idx_r    <= '0;
        fill_r      <= '0;
        push_rem_r  <= '0;
        push_res_r  <= '0;
        push_slot_r <= '0;
      end
    end
  end

  assign sts.burst_start = is_read_cmd && (avail != '0);
  assign sts.burst_last  = burst_last;
  assign sts.out_free    = out_free;
  assign out_valid       = out_valid_r;
  assign out_beat        = out_beat_r;

`ifndef NO_ASSERTIONS
  a_fill_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fill_r} + {1'b0, push_res_r}) <= {1'b0, cap_r})
    else $error("fill plus open run exceeds capacity");
  a_indices_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (mfrb_pkg::WIDE_W'(rd_idx_r) < mfrb_pkg::WIDE_W'(cap_r)) &&
    (mfrb_pkg::WIDE_W'(wr_idx_r) < mfrb_pkg::WIDE_W'(cap_r)))
    else $error("ring index beyond capacity");
  a_open_run_within_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    push_rem_r <= push_res_r)
    else $error("push run owes more frames than reserved");
  a_frame_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.frame_load |=> out_valid_r)
    else $error("loaded frame not presented");
`endif

endmodule
`default_nettype wire

@@ rtl/core/multichannel_frame_ring_buffer_core.sv @@
// Top level of the multichannel frame ring buffer: channels, sequencer and datapath.
// A single-result command shows its result in the cycle after its input beat.
// Pop/peek: each frame takes a RAM read, then a result load that waits while the
//   result register is busy, up to MAX_BURST frames per request; in_ready stays low.
// Throughput: one input beat per cycle for non-burst commands while results drain.
// Reset (rst_n low, synchronous): empty ring, generation 0, 2 channels, 1024 frames.
`default_nettype none
module multichannel_frame_ring_buffer_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfrb_cfg_if.sink   cfg_bus,
  mfrb_in_if.sink    in_bus,
  mfrb_out_if.source out_bus
);

  mfrb_pkg::mfrb_in_beat_t   in_beat;
  mfrb_pkg::mfrb_out_beat_t  out_beat;
  mfrb_pkg::mfrb_ctl_t       ctl;
  mfrb_pkg::mfrb_sts_t       sts;
  logic                      in_ready;
  logic                      out_valid;

  assign in_beat.command        = in_bus.command;
  assign in_beat.frame_count    = in_bus.frame_count;
  assign in_beat.generation_tag = in_bus.generation_tag;
  assign in_beat.samples[0]     = in_bus.sample_ch0;
  assign in_beat.samples[1]     = in_bus.sample_ch1;
  assign in_beat.samples[2]     = in_bus.sample_ch2;
  assign in_beat.samples[3]     = in_bus.sample_ch3;
  assign in_beat.samples[4]     = in_bus.sample_ch4;
  assign in_beat.samples[5]     = in_bus.sample_ch5;
  assign in_beat.samples[6]     = in_bus.sample_ch6;
  assign in_beat.samples[7]     = in_bus.sample_ch7;
  assign in_bus.ready           = in_ready;

  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid       = out_valid;
  assign out_bus.accepted    = out_beat.accepted;
  assign out_bus.count_done  = out_beat.count_done;
  assign out_bus.out_ch0     = out_beat.samples[0];
  assign out_bus.out_ch1     = out_beat.samples[1];
  assign out_bus.out_ch2     = out_beat.samples[2];
  assign out_bus.out_ch3     = out_beat.samples[3];
  assign out_bus.out_ch4     = out_beat.samples[4];
  assign out_bus.out_ch5     = out_beat.samples[5];
  assign out_bus.out_ch6     = out_beat.samples[6];
  assign out_bus.out_ch7     = out_beat.samples[7];
  assign out_bus.last_of_run = out_beat.last_of_run;

  mfrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mfrb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_bus.valid),
    .cfg_index (cfg_bus.index),
    .cfg_data  (cfg_bus.data),
    .in_beat   (in_beat),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

@@ tb/multichannel_frame_ring_buffer_core_test.sv @@
// Self-checking testbench of the frame ring buffer core: directed and random traffic.
`timescale 1ns / 100ps
module multichannel_frame_ring_buffer_core_test;
  import mfrb_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd2;
  localparam int                   QUIET_LIMIT = 2000;

  logic clk;
  logic rst_n;

  mfrb_cfg_if cfg_port();
  mfrb_in_if  in_port();
  mfrb_out_if out_port();

  multichannel_frame_ring_buffer_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_port),
    .in_bus  (in_port),
    .out_bus (out_port)
  );

  logic [SAMPLE_W-1:0] ring_mem [DEPTH_FRAMES][LANES];
  int unsigned lanes_on  = CH_RESET;
  int unsigned ring_cap  = CAP_RESET;
  int unsigned rd_slot   = 0;
  int unsigned wr_slot   = 0;
  int unsigned filled    = 0;
  int unsigned owed      = 0;
  int unsigned fill_slot = 0;
  int unsigned reserved  = 0;
  logic [GEN_W-1:0] generation = '0;

  mfrb_out_beat_t results_due[$];
  mfrb_out_beat_t got_beat;
  mfrb_out_beat_t want_beat;

  int unsigned beats_sent     = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned sink_wait      = 0;
  bit          in_lazy        = 1'b1;
  bit          out_lazy       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned next_slot(input int unsigned s);
    return (s + 1 >= ring_cap) ? 0 : s + 1;
  endfunction

  function automatic mfrb_in_beat_t make_beat(input logic [CMD_W-1:0] op,
                                              input int unsigned count,
                                              input logic [GEN_W-1:0] tag);
    mfrb_in_beat_t b;
    b.command        = op;
    b.frame_count    = count[CNT_W-1:0];
    b.generation_tag = tag;
    for (int j = 0; j < LANES; j++) b.samples[j] = $urandom;
    return b;
  endfunction

  function automatic int unsigned read_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MAX_BURST, 2047);
      2: return 2047;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic apply_command(input mfrb_in_beat_t b);
    mfrb_out_beat_t r;
    int unsigned req, n, s;
    logic ok;
    r = '0;
    r.accepted = 1'b1;
    r.last_of_run = 1'b1;
    req = b.frame_count;
    case (b.command)
      CMD_PUSH_START: begin
        owed = 0;
        reserved = 0;
        ok = (b.generation_tag == generation) && (req <= ring_cap - filled);
        if (ok) begin
          owed = req;
          reserved = req;
          fill_slot = wr_slot;
        end
        r.accepted = ok;
        results_due.push_back(r);
      end
      CMD_PUSH_FRAME: begin
        if (owed != 0) begin
          for (int j = 0; j < lanes_on; j++) ring_mem[fill_slot][j] = b.samples[j];
          fill_slot = next_slot(fill_slot);
          owed--;
          if (owed == 0) begin
            wr_slot = fill_slot;
            filled += reserved;
            if (filled > ring_cap) filled = ring_cap;
            reserved = 0;
          end
        end
        results_due.push_back(r);
      end
      CMD_POP, CMD_PEEK: begin
        n = req;
        if (n > filled) n = filled;
        if (n > MAX_BURST) n = MAX_BURST;
        if (n == 0) begin
          results_due.push_back(r);
        end else begin
          s = rd_slot;
          for (int k = 0; k < n; k++) begin
            r.count_done = n[CNT_W-1:0];
            for (int j = 0; j < LANES; j++)
              r.samples[j] = (j < lanes_on) ? ring_mem[s][j] : '0;
            r.last_of_run = (k + 1 == n);
            results_due.push_back(r);
            s = next_slot(s);
          end
          if (b.command == CMD_POP) begin
            rd_slot = s;
            filled -= n;
          end
        end
      end
      CMD_DISCARD: begin
        n = (req > filled) ? filled : req;
        rd_slot = (rd_slot + n) % ring_cap;
        filled -= n;
        r.count_done = n[CNT_W-1:0];
        results_due.push_back(r);
      end
      CMD_RESET: begin
        generation = b.generation_tag;
        rd_slot = wr_slot;
        filled = 0;
        owed = 0;
        reserved = 0;
        fill_slot = wr_slot;
        results_due.push_back(r);
      end
      default: begin
        results_due.push_back(r);
      end
    endcase
  endtask

  task automatic send_beat(input mfrb_in_beat_t b);
    int unsigned gap;
    gap = in_lazy ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_port.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_port.valid          <= 1'b1;
    in_port.command        <= b.command;
    in_port.frame_count    <= b.frame_count;
    in_port.generation_tag <= b.generation_tag;
    in_port.sample_ch0     <= b.samples[0];
    in_port.sample_ch1     <= b.samples[1];
    in_port.sample_ch2     <= b.samples[2];
    in_port.sample_ch3     <= b.samples[3];
    in_port.sample_ch4     <= b.samples[4];
    in_port.sample_ch5     <= b.samples[5];
    in_port.sample_ch6     <= b.samples[6];
    in_port.sample_ch7     <= b.samples[7];
    do @(posedge clk); while (!in_port.ready);
    apply_command(b);
    beats_sent++;
  endtask

  // drop valid, wait for every expected beat, then let the pipeline empty
  task automatic settle();
    in_port.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    cfg_port.valid <= 1'b1;
    cfg_port.index <= idx;
    cfg_port.data  <= val;
    do @(posedge clk); while (!cfg_port.ready);
    cfg_port.valid <= 1'b0;
    reg_writes++;
    if (idx == CFG_CHANNEL_COUNT) begin
      v = val[3:0];
      lanes_on = (v < 1) ? 1 : (v > MAX_CHANNELS) ? MAX_CHANNELS : v;
    end else if (idx == CFG_CAPACITY) begin
      v = val;
      ring_cap = (v < 1) ? 1 : (v > DEPTH_FRAMES) ? DEPTH_FRAMES : v;
    end
    if (idx == CFG_CHANNEL_COUNT || idx == CFG_CAPACITY) begin
      rd_slot = 0;
      wr_slot = 0;
      filled = 0;
      owed = 0;
      reserved = 0;
      fill_slot = 0;
    end
    @(posedge clk);
  endtask

  task automatic test_empty_ring();
    send_beat(make_beat(CMD_PEEK, 2047, '0));
    send_beat(make_beat(CMD_POP, 0, '0));
    send_beat(make_beat(CMD_PUSH_START, 1, 16'hFFFF));
    send_beat(make_beat(CMD_PUSH_START, 0, generation));
    send_beat(make_beat(CMD_PUSH_FRAME, 1, '0));
    send_beat(make_beat(CMD_SPARE_6, 2047, 16'hFFFF));
    send_beat(make_beat(CMD_SPARE_7, 0, '0));
  endtask

  task automatic test_push_and_read();
    mfrb_in_beat_t b;
    send_beat(make_beat(CMD_PUSH_START, 3, generation));
    b = make_beat(CMD_PUSH_FRAME, 2047, 16'hFFFF);
    b.samples = '1;
    send_beat(b);
    b = make_beat(CMD_PUSH_FRAME, 0, '0);
    b.samples = '0;
    send_beat(b);
    send_beat(make_beat(CMD_PUSH_FRAME, 5, '0));
    send_beat(make_beat(CMD_PEEK, 2047, '0));
    send_beat(make_beat(CMD_POP, 1, '0));
    send_beat(make_beat(CMD_DISCARD, 2047, '0));
    send_beat(make_beat(CMD_POP, 1, '0));
  endtask

  task automatic test_admission();
    send_beat(make_beat(CMD_PUSH_START, DEPTH_FRAMES + 1, generation));
    send_beat(make_beat(CMD_PUSH_START, DEPTH_FRAMES, generation));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_PUSH_START, 2, generation));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_RESET, 0, 16'hFFFF));
    send_beat(make_beat(CMD_PUSH_START, 1, '0));
    send_beat(make_beat(CMD_PUSH_START, 1, 16'hFFFF));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_POP, 1, '0));
    send_beat(make_beat(CMD_RESET, 0, '0));
  endtask

  task automatic test_register_extremes();
    settle();
    write_register(CFG_CHANNEL_COUNT, '0);
    write_register(CFG_CAPACITY, '0);
    send_beat(make_beat(CMD_PUSH_START, 1, generation));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_PUSH_START, 1, generation));
    settle();
    write_register(CFG_UNUSED, '1);
    send_beat(make_beat(CMD_POP, 1, '0));
    settle();
    write_register(CFG_CHANNEL_COUNT, 11'd15);
    write_register(CFG_CAPACITY, '1);
    send_beat(make_beat(CMD_PUSH_START, 2, generation));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_PUSH_FRAME, 0, '0));
    send_beat(make_beat(CMD_PEEK, 2047, '0));
    settle();
  endtask

  task automatic random_push_run();
    int unsigned len, cut, top;
    top = (ring_cap < 6) ? ring_cap : 6;
    if ($urandom_range(0, 14) == 0) top = (ring_cap < 70) ? ring_cap : 70;
    len = $urandom_range(1, top);
    if (len > ring_cap - filled && $urandom_range(0, 3) != 0)
      send_beat(make_beat(CMD_POP, MAX_BURST, GEN_W'($urandom)));
    send_beat(make_beat(CMD_PUSH_START, len, generation));
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
    for (int k = 0; k < cut; k++)
      send_beat(make_beat(CMD_PUSH_FRAME, $urandom_range(0, 2047), GEN_W'($urandom)));
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    int unsigned stop_at, pick;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) begin
        in_lazy  = ($urandom_range(0, 3) != 0);
        out_lazy = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
        random_push_run();
      else if (pick < 60)
        send_beat(make_beat(CMD_POP, read_count(), GEN_W'($urandom)));
      else if (pick < 72)
        send_beat(make_beat(CMD_PEEK, read_count(), GEN_W'($urandom)));
      else if (pick < 80)
        send_beat(make_beat(CMD_DISCARD, read_count(), GEN_W'($urandom)));
      else if (pick < 84)
        send_beat(make_beat(CMD_RESET, read_count(), GEN_W'($urandom)));
      else if (pick < 88)
        send_beat(make_beat(CMD_PUSH_START, $urandom_range(0, 4),
                            generation ^ (16'h1 << $urandom_range(0, 15))));
      else if (pick < 92)
        send_beat(make_beat(CMD_PUSH_START, $urandom_range(0, 2047), generation));
      else if (pick < 96)
        send_beat(make_beat(CMD_PUSH_FRAME, $urandom_range(0, 2047), GEN_W'($urandom)));
      else
        send_beat(make_beat($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7,
                            $urandom_range(0, 2047), GEN_W'($urandom)));
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_port.valid && out_port.ready) begin
      got_beat.accepted    = out_port.accepted;
      got_beat.count_done  = out_port.count_done;
      got_beat.samples[0]  = out_port.out_ch0;
      got_beat.samples[1]  = out_port.out_ch1;
      got_beat.samples[2]  = out_port.out_ch2;
      got_beat.samples[3]  = out_port.out_ch3;
      got_beat.samples[4]  = out_port.out_ch4;
      got_beat.samples[5]  = out_port.out_ch5;
      got_beat.samples[6]  = out_port.out_ch6;
      got_beat.samples[7]  = out_port.out_ch7;
      got_beat.last_of_run = out_port.last_of_run;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected", $time);
      end else begin
        want_beat = results_due.pop_front();
        frames_checked++;
        if (got_beat.accepted !== want_beat.accepted) begin
          mismatches++;
          $display("%0t: accepted expected %0b got %0b", $time,
                   want_beat.accepted, got_beat.accepted);
        end
        if (got_beat.count_done !== want_beat.count_done) begin
          mismatches++;
          $display("%0t: count_done expected %0d got %0d", $time,
                   want_beat.count_done, got_beat.count_done);
        end
        for (int j = 0; j < LANES; j++)
          if (got_beat.samples[j] !== want_beat.samples[j]) begin
            mismatches++;
            $display("%0t: out_ch%0d expected %h got %h", $time, j,
                     want_beat.samples[j], got_beat.samples[j]);
          end
        if (got_beat.last_of_run !== want_beat.last_of_run) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b got %0b", $time,
                   want_beat.last_of_run, got_beat.last_of_run);
        end
      end
      sink_wait = out_lazy ? $urandom_range(0, 6) : 0;
    end
    if (sink_wait != 0) begin
      out_port.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_port.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_port.valid && in_port.ready) || (out_port.valid && out_port.ready) ||
        (cfg_port.valid && cfg_port.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d beats still due", $time,
               quiet_cycles, results_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned chan_set [5];
    int unsigned cap_set [5];
    chan_set = '{8, 1, 3, 5, 2};
    cap_set  = '{1024, 1, 5, 64, 200};
    rst_n                  <= 1'b0;
    in_port.valid          <= 1'b0;
    in_port.command        <= '0;
    in_port.frame_count    <= '0;
    in_port.generation_tag <= '0;
    in_port.sample_ch0     <= '0;
    in_port.sample_ch1     <= '0;
    in_port.sample_ch2     <= '0;
    in_port.sample_ch3     <= '0;
    in_port.sample_ch4     <= '0;
    in_port.sample_ch5     <= '0;
    in_port.sample_ch6     <= '0;
    in_port.sample_ch7     <= '0;
    cfg_port.valid         <= 1'b0;
    cfg_port.index         <= '0;
    cfg_port.data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_push_and_read();
    test_admission();
    test_register_extremes();
    for (int p = 0; p < 5; p++) begin
      write_register(CFG_CHANNEL_COUNT, CFG_DATA_W'(chan_set[p]));
      write_register(CFG_CAPACITY, CFG_DATA_W'(cap_set[p]));
      test_random_traffic(62);
    end
    settle();

    $display("Sent %0d input beats, checked %0d result beats, %0d register writes",
             beats_sent, frames_checked, reg_writes);
    $display("Settings ran from 1 to 8 channels and from 1 to 1024 frames of capacity");
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
